@@ hw/rtl/field_block_metrics_assert.svh @@
// Assertion macros for the checker file of the block.
// Every macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef FIELD_BLOCK_METRICS_ASSERT_SVH
`define FIELD_BLOCK_METRICS_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define FBM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define FBM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/fbm_pkg.sv @@
// ----------------------------------------------------------------------------
// fbm_pkg
// Types and constants of the field block metrics engine.
// ----------------------------------------------------------------------------
package fbm_pkg;

  localparam int LANES      = 8;
  localparam int PIX_W      = 8;
  localparam int POS_W      = 3;
  localparam int SAD_SUM_W  = 11;
  localparam int COMB_SUM_W = 13;
  localparam int VAR_SUM_W  = 11;
  localparam int SAD_ACC_W  = 13;
  localparam int COMB_ACC_W = 15;
  localparam int VAR_ACC_W  = 13;

  // item positions inside a block
  localparam logic [POS_W-1:0] POS_FIRST    = 3'd0;
  localparam logic [POS_W-1:0] POS_VAR_LAST = 3'd3;
  localparam logic [POS_W-1:0] POS_LAST     = 3'd4;
  localparam logic [POS_W-1:0] POS_IDLE     = 3'd5;

  typedef struct packed {
    logic [63:0] line_a;
    logic [63:0] line_b;
    logic        block_start;
  } in_item_t;

  typedef struct packed {
    logic [12:0] sad_sum;
    logic [14:0] comb_sum;
    logic [14:0] variation_sum;
  } out_item_t;

  // per-pixel terms found by one lane
  typedef struct packed {
    logic [7:0] sad;
    logic [9:0] comb;
    logic [7:0] vari;
  } lane_terms_t;

  // control that travels with the lane stage
  typedef struct packed {
    logic valid;
    logic clear;
    logic add_sc;
    logic add_var;
    logic emit;
  } s1_ctrl_t;

endpackage

@@ hw/rtl/fbm_lane.sv @@
// ----------------------------------------------------------------------------
// fbm_lane
// One pixel column: absolute differences and comb terms, registered.
// ----------------------------------------------------------------------------
module fbm_lane (
  input  logic                 clk,
  input  logic                 en,
  input  logic [7:0]           pa,
  input  logic [7:0]           pb,
  input  logic [7:0]           ca,
  input  logic [7:0]           cb,
  output fbm_pkg::lane_terms_t terms_r
);
  import fbm_pkg::*;

  logic signed [8:0] d_sad;
  logic signed [8:0] d_var;
  logic signed [9:0] d_ca;
  logic signed [9:0] d_cb;
  logic [8:0]        abs_ca;
  logic [8:0]        abs_cb;
  lane_terms_t       terms_nxt;

  assign d_sad = $signed({1'b0, pa}) - $signed({1'b0, cb});
  assign d_var = $signed({1'b0, pa}) - $signed({1'b0, ca});
  assign d_ca  = $signed({1'b0, pa, 1'b0}) - $signed({2'b00, pb}) - $signed({2'b00, cb});
  assign d_cb  = $signed({1'b0, cb, 1'b0}) - $signed({2'b00, pa}) - $signed({2'b00, ca});

  always_comb begin
    abs_ca = d_ca[9] ? 9'(-d_ca) : d_ca[8:0];
    abs_cb = d_cb[9] ? 9'(-d_cb) : d_cb[8:0];
    terms_nxt.sad  = d_sad[8] ? 8'(-d_sad) : d_sad[7:0];
    terms_nxt.vari = d_var[8] ? 8'(-d_var) : d_var[7:0];
    terms_nxt.comb = {1'b0, abs_ca} + {1'b0, abs_cb};
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (en) begin
      terms_r <= terms_nxt;
    end
  end

endmodule

@@ hw/rtl/fbm_merge.sv @@
// ----------------------------------------------------------------------------
// fbm_merge
// Sum the lane terms, accumulate over the block and hold the result.
// ----------------------------------------------------------------------------
module fbm_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  fbm_pkg::s1_ctrl_t    ctrl,
  input  fbm_pkg::lane_terms_t terms [fbm_pkg::LANES],
  input  logic                 out_stall,
  output logic                 out_valid,
  output fbm_pkg::out_item_t   out_data
);
  import fbm_pkg::*;

  logic [SAD_SUM_W-1:0]  sad_sum;
  logic [COMB_SUM_W-1:0] comb_sum;
  logic [VAR_SUM_W-1:0]  var_sum;
  logic [SAD_ACC_W-1:0]  sad_acc_r, sad_acc_nxt;
  logic [COMB_ACC_W-1:0] comb_acc_r, comb_acc_nxt;
  logic [VAR_ACC_W-1:0]  var_acc_r, var_acc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;
  logic                  take;

  always_comb begin
    sad_sum  = '0;
    comb_sum = '0;
    var_sum  = '0;
    for (int i = 0; i < LANES; i++) begin
      sad_sum  = sad_sum  + SAD_SUM_W'(terms[i].sad);
      comb_sum = comb_sum + COMB_SUM_W'(terms[i].comb);
      var_sum  = var_sum  + VAR_SUM_W'(terms[i].vari);
    end
  end

  assign take = ctrl.valid && advance;

  always_comb begin
    sad_acc_nxt  = ctrl.clear ? '0 : sad_acc_r;
    comb_acc_nxt = ctrl.clear ? '0 : comb_acc_r;
    var_acc_nxt  = ctrl.clear ? '0 : var_acc_r;
    if (ctrl.add_sc) begin
      sad_acc_nxt  = sad_acc_nxt + SAD_ACC_W'(sad_sum);
      comb_acc_nxt = comb_acc_nxt + COMB_ACC_W'(comb_sum);
    end
    if (ctrl.add_var) begin
      var_acc_nxt = var_acc_nxt + VAR_ACC_W'(var_sum);
    end
    out_data_nxt.sad_sum       = sad_acc_nxt;
    out_data_nxt.comb_sum      = comb_acc_nxt;
    out_data_nxt.variation_sum = {var_acc_nxt, 2'b00};
    if (take && ctrl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sad_acc_r   <= '0;
      comb_acc_r  <= '0;
      var_acc_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        sad_acc_r  <= sad_acc_nxt;
        comb_acc_r <= comb_acc_nxt;
        var_acc_r  <= var_acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && ctrl.emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/field_block_metrics.sv @@
// ----------------------------------------------------------------------------
// field_block_metrics
// Inverse-telecine metrics (SAD, line comb, vertical variation) of one
// 8-pixel by 4-field-line block delivered as five transactions.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_stall   | fbm_pkg::in_item_t  (line_a, line_b, block_start)
//  out_    | out | out_valid/out_stall | fbm_pkg::out_item_t (sad_sum, comb_sum, variation_sum)
//
// One input transaction per cycle while in_stall is low. The fifth transaction
// of a block goes through the lane registers, and its result into the output register.
// Three register levels: the line and position registers at the input, the
// eight lane registers, and the accumulators with the output register.
// in_stall rises only while a result waits under out_stall and the lane stage
// holds the next block's closing transaction; everything else keeps flowing.
// rst_n is synchronous: position goes idle, accumulators and lines clear.
// ----------------------------------------------------------------------------
module field_block_metrics (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fbm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fbm_pkg::out_item_t out_data
);
  import fbm_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [63:0]      prev_a_r;
  logic [63:0]      prev_b_r;
  logic [POS_W-1:0] k;
  s1_ctrl_t         s1_r, s1_nxt;
  logic             s1_adv;
  logic             accept;
  logic             live;
  lane_terms_t      terms [LANES];

  // Hold the lane stage only if it would load a result over one still waiting.
  assign s1_adv   = !(s1_r.valid && s1_r.emit && out_valid && out_stall);
  assign in_stall = !s1_adv;
  assign accept   = in_valid && s1_adv;

  // Drop transactions outside a block; a block start always restarts.
  assign live    = accept && (in_data.block_start || (pos_r < POS_IDLE));
  assign k       = in_data.block_start ? POS_FIRST : pos_r;
  assign pos_nxt = k + POS_W'(1);

  always_comb begin
    s1_nxt.valid   = live;
    s1_nxt.clear   = in_data.block_start;
    // the first transaction of a block only latches its lines
    s1_nxt.add_sc  = (k != POS_FIRST);
    // vertical variation covers the first three line pairs of A
    s1_nxt.add_var = (k != POS_FIRST) && (k <= POS_VAR_LAST);
    s1_nxt.emit    = (k == POS_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_IDLE;
      prev_a_r <= '0;
      prev_b_r <= '0;
      s1_r     <= '0;
    end else begin
      if (s1_adv) begin
        s1_r <= s1_nxt;
      end
      if (live) begin
        pos_r    <= pos_nxt;
        prev_a_r <= in_data.line_a;
        prev_b_r <= in_data.line_b;
      end
    end
  end

  // One lane per pixel column: previous A/B lines against current ones.
  for (genvar j = 0; j < LANES; j++) begin : g_lane
    fbm_lane u_lane (
      .clk     (clk),
      .en      (s1_adv),
      .pa      (prev_a_r[PIX_W*j +: PIX_W]),
      .pb      (prev_b_r[PIX_W*j +: PIX_W]),
      .ca      (in_data.line_a[PIX_W*j +: PIX_W]),
      .cb      (in_data.line_b[PIX_W*j +: PIX_W]),
      .terms_r (terms[j])
    );
  end

  // Merge lanes, accumulate and present the block result.
  fbm_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (s1_adv),
    .ctrl      (s1_r),
    .terms     (terms),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/fbm_checker.sv @@
// ----------------------------------------------------------------------------
// fbm_checker
// Port-level checks on the field block metrics engine, bound to the top.
// ----------------------------------------------------------------------------
`include "field_block_metrics_assert.svh"

module fbm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input fbm_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input fbm_pkg::out_item_t out_data
);
  import fbm_pkg::*;

  `FBM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
  `FBM_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_data), "result changed under stall")
  `FBM_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with no result waiting")
  `FBM_ASSERT_IMP(a_result_src, $rose(out_valid), $past(in_valid && !in_stall && !in_data.block_start, 2), "result without a closing transaction")

endmodule

bind field_block_metrics fbm_checker u_fbm_checker (.*);

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for field_block_metrics. It streams five-transaction
// blocks and stray or broken sequences into the block with bursty input
// traffic and a patterned output stall. A scoreboard predicts the SAD,
// line-comb and vertical-variation sums of every completed block and
// compares each result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fbm_pkg::*;

  localparam int ITEMS_TARGET = 550;
  localparam int DRAIN_CYCLES = 16;
  localparam int RUN_LIMIT_NS = 2_000_000;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow state of the block plus the queue of pending results
  // --------------------------------------------------------------------------
  class metrics_scoreboard;
    logic [63:0] last_a;
    logic [63:0] last_b;
    logic [2:0]  pos;
    logic [12:0] sad_acc;
    logic [14:0] comb_acc;
    logic [12:0] var_acc;
    out_item_t   pending_sums[$];
    int          errors;
    int          processed;

    function new();
      last_a    = '0;
      last_b    = '0;
      pos       = POS_IDLE;
      sad_acc   = '0;
      comb_acc  = '0;
      var_acc   = '0;
      errors    = 0;
      processed = 0;
    endfunction

    function int absdiff(int v);
      return (v < 0) ? -v : v;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // Advance the shadow state by one accepted input transaction.
    function void note_input(in_item_t it);
      int pa, pb, ca, cb;
      out_item_t sums;
      if (it.block_start) begin
        pos      = POS_FIRST;
        sad_acc  = '0;
        comb_acc = '0;
        var_acc  = '0;
      end else if (pos > POS_LAST) begin
        return;
      end
      processed++;
      if (pos != POS_FIRST) begin
        for (int j = 0; j < LANES; j++) begin
          pa = int'(last_a[8*j +: 8]);
          pb = int'(last_b[8*j +: 8]);
          ca = int'(it.line_a[8*j +: 8]);
          cb = int'(it.line_b[8*j +: 8]);
          sad_acc  += 13'(absdiff(pa - cb));
          comb_acc += 15'(absdiff(2*pa - pb - cb) + absdiff(2*cb - pa - ca));
          if (pos <= POS_VAR_LAST)
            var_acc += 13'(absdiff(pa - ca));
        end
      end
      last_a = it.line_a;
      last_b = it.line_b;
      pos    = pos + 3'd1;
      if (pos == POS_IDLE) begin
        sums.sad_sum       = sad_acc;
        sums.comb_sum      = comb_acc;
        sums.variation_sum = {var_acc, 2'b00};
        pending_sums.push_back(sums);
      end
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_sums.size() == 0) begin
        report($sformatf("unexpected result sad=%0d comb=%0d var=%0d",
                         got.sad_sum, got.comb_sum, got.variation_sum));
        return;
      end
      want = pending_sums.pop_front();
      if (got.sad_sum !== want.sad_sum)
        report($sformatf("sad_sum got %0d want %0d", got.sad_sum, want.sad_sum));
      if (got.comb_sum !== want.comb_sum)
        report($sformatf("comb_sum got %0d want %0d", got.comb_sum, want.comb_sum));
      if (got.variation_sum !== want.variation_sum)
        report($sformatf("variation_sum got %0d want %0d",
                         got.variation_sum, want.variation_sum));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  metrics_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  field_block_metrics DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // --------------------------------------------------------------------------
  // Input driver
  // --------------------------------------------------------------------------
  int burst_left = 0;

  // Pick a line: fully random, pure black/white pixels, or a mix of both.
  function automatic logic [63:0] random_line();
    logic [63:0] v;
    int          sel;
    sel = $urandom_range(0, 2);
    v   = {$urandom(), $urandom()};
    if (sel != 0) begin
      for (int j = 0; j < LANES; j++) begin
        if (sel == 1 || $urandom_range(0, 1) == 0)
          v[8*j +: 8] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
      end
    end
    return v;
  endfunction

  // Present one transaction and hold it until the block takes it. Close the
  // burst with an idle gap when its length runs out.
  task automatic send(input logic [63:0] a, input logic [63:0] b,
                      input logic start);
    in_item_t it;
    it.line_a      = a;
    it.line_b      = b;
    it.block_start = start;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // Mostly short bursts, now and then a long unbroken stretch.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Well-formed block: start flag on the first transaction only.
  task automatic send_block();
    for (int k = 0; k < 5; k++)
      send(random_line(), random_line(), k == 0);
  endtask

  // --------------------------------------------------------------------------
  // Output side: check accepted results, stall on a pattern of its own
  // --------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_data);
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(8, 64);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= 1'b1;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int sel;
    int n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle after reset: no start flag, so drop it.
    send(64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF, 1'b0);

    // All-zero block: every sum is zero.
    for (int k = 0; k < 5; k++)
      send(64'h0, 64'h0, k == 0);

    // A white, B black everywhere: SAD and comb reach their maxima.
    for (int k = 0; k < 5; k++)
      send(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, k == 0);

    // A alternates white/black line to line: variation reaches its maximum.
    for (int k = 0; k < 5; k++)
      send((k % 2 == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0,
           (k % 2 == 0) ? 64'h0 : 64'hFFFF_FFFF_FFFF_FFFF, k == 0);

    // Transaction after the fifth: drop it.
    send(64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555, 1'b0);

    // Restart mid-block: abandon the partial block, then finish the new one.
    send(random_line(), random_line(), 1'b1);
    send(random_line(), random_line(), 1'b0);
    send_block();

    // Random part: mostly clean blocks, some broken and stray traffic.
    while (sb.processed < ITEMS_TARGET) begin
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        send_block();
      end else if (sel < 88) begin
        n = $urandom_range(1, 4);
        send(random_line(), random_line(), 1'b1);
        for (int k = 0; k < n; k++)
          send(random_line(), random_line(), 1'b0);
      end else if (sel < 95) begin
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++)
          send(random_line(), random_line(), 1'b0);
      end else begin
        for (int k = 0; k < 5; k++)
          send(random_line(), random_line(), $urandom_range(0, 3) == 0);
      end
    end

    in_valid <= 1'b0;
    while (sb.pending_sums.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending_sums.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_sums.size()));
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout after %0d ns", RUN_LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
